// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tfdt_pkg.sv =====
package tfdt_pkg;

   localparam int SCREEN_HALF = 256;
   localparam int ROW_PITCH   = 512;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0] HALF_RESET = 8'd255;

   localparam int PIX_W   = 9;
   localparam int VTX_W   = 13;
   localparam int Z_W     = 16;
   localparam int EDGE_W  = 30;
   localparam int ACC_W   = 48;
   localparam int DIV_STEPS = 16;
   localparam int CNT_W   = 4;

   localparam logic signed [Z_W-1:0] Z_FAR = 16'sh7FFF;

   // gray = |z - 1000| * 255 / 1000, saturated
   localparam int GRAY_OFFSET = 1000;
   localparam int GRAY_SCALE  = 255;
   localparam int GRAY_SAT    = 256 * 1000;
   localparam int RECIP       = 268436;   // ceil(2^28 / 1000)
   localparam int RECIP_SHIFT = 28;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_AREA,
      OP_WA,
      OP_WB,
      OP_CHECK,
      OP_MAC,
      OP_DIVINIT,
      OP_DIV,
      OP_FINAL,
      OP_TEST,
      OP_GRAY
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] mac_sel;
   } cmd_type;

   typedef struct packed {
      logic offscreen;
      logic covered;
   } status_type;

endpackage

// ===== rtl/core/tfdt_ram.sv =====
module tfdt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tfdt_dp.sv =====
module tfdt_dp #(
   parameter int SCREEN_HALF = tfdt_pkg::SCREEN_HALF,
   parameter int ROW_PITCH   = tfdt_pkg::ROW_PITCH,
   localparam int DEPTH = 2 * SCREEN_HALF * ROW_PITCH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tfdt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfdt_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic signed [tfdt_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic signed [tfdt_pkg::PIX_W-1:0]   req_pixel_y,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v0_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v0_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v0_z,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v1_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v1_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v1_z,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v2_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v2_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v2_z,
   input  tfdt_pkg::cmd_type                   cmd,
   input  logic [AW-1:0]                       clr_addr,
   output tfdt_pkg::status_type                st,
   output logic                                rsp_covered,
   output logic                                rsp_depth_written,
   output logic [7:0]                          rsp_gray_level,
   output logic signed [tfdt_pkg::Z_W-1:0]     rsp_depth_value
);

   localparam int VW = tfdt_pkg::VTX_W;
   localparam int EW = tfdt_pkg::EDGE_W;
   localparam int AC = tfdt_pkg::ACC_W;
   localparam int ZW = tfdt_pkg::Z_W;

   logic [7:0] hw_ff, hw_in, hh_ff, hh_in;

   logic signed [tfdt_pkg::PIX_W-1:0] px_ff, py_ff;
   logic signed [VW-1:0] vx_ff [3];
   logic signed [VW-1:0] vy_ff [3];
   logic signed [ZW-1:0] vz_ff [3];
   logic                 off_ff, off_in;
   logic [AW-1:0]        addr_ff, addr_in;

   logic signed [EW-1:0] area_ff, wa_ff, wb_ff, wc_ff;
   logic                 cov_ff;
   logic signed [AC-1:0] acc_ff;
   logic                 neg_ff;
   logic [EW-1:0]        rem_ff;
   logic [15:0]          dvd_ff, quo_ff;
   logic signed [ZW-1:0] z_ff;
   logic                 wr_ff;
   logic [23:0]          t_ff;
   logic [7:0]           gray_ff;

   // config registers
   always_comb begin
      hw_in = hw_ff;
      hh_in = hh_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tfdt_pkg::CSR_HALF_WIDTH:  hw_in = csr_write_data;
            tfdt_pkg::CSR_HALF_HEIGHT: hh_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= tfdt_pkg::HALF_RESET;
         hh_ff <= tfdt_pkg::HALF_RESET;
      end else begin
         hw_ff <= hw_in;
         hh_ff <= hh_in;
      end
   end

   // screen window and store address
   logic signed [9:0]  xw, yw, hwv, hhv;
   logic signed [12:0] col, row;

   always_comb begin
      xw  = 10'(req_pixel_x);
      yw  = 10'(req_pixel_y);
      hwv = $signed({2'b00, hw_ff});
      hhv = $signed({2'b00, hh_ff});
      col = 13'(req_pixel_x) + 13'(SCREEN_HALF);
      row = 13'(req_pixel_y) + 13'(SCREEN_HALF);
      off_in = (xw > hwv) || (xw < -hwv) || (yw > hhv) || (yw < -hhv)
             || (col < 13'sd0) || (col >= 13'(ROW_PITCH))
             || (row < 13'sd0) || (row >= 13'(2 * SCREEN_HALF));
      addr_in = AW'(row[11:0]) * AW'(ROW_PITCH) + AW'(col[11:0]);
   end

   // shared edge unit
   logic signed [VW-1:0] ep_x, ep_y, ea_x, ea_y, eb_x, eb_y;
   logic signed [VW:0]   dx1, dy1, dx2, dy2;
   logic signed [2*VW+1:0] prod_a, prod_b;
   logic signed [EW-1:0] edge_v;

   always_comb begin
      case (cmd.op)
         tfdt_pkg::OP_AREA: begin
            ep_x = vx_ff[0]; ep_y = vy_ff[0];
            ea_x = vx_ff[1]; ea_y = vy_ff[1];
            eb_x = vx_ff[2]; eb_y = vy_ff[2];
         end
         tfdt_pkg::OP_WA: begin
            ep_x = VW'(px_ff); ep_y = VW'(py_ff);
            ea_x = vx_ff[1];   ea_y = vy_ff[1];
            eb_x = vx_ff[2];   eb_y = vy_ff[2];
         end
         default: begin
            ep_x = VW'(px_ff); ep_y = VW'(py_ff);
            ea_x = vx_ff[2];   ea_y = vy_ff[2];
            eb_x = vx_ff[0];   eb_y = vy_ff[0];
         end
      endcase
      dx1 = (VW+1)'(ep_x) - (VW+1)'(ea_x);
      dy2 = (VW+1)'(eb_y) - (VW+1)'(ea_y);
      dy1 = (VW+1)'(ep_y) - (VW+1)'(ea_y);
      dx2 = (VW+1)'(eb_x) - (VW+1)'(ea_x);
      prod_a = dx1 * dy2;
      prod_b = dy1 * dx2;
      edge_v = EW'(prod_b) - EW'(prod_a);
   end

   // sign fix and interior test
   logic signed [EW-1:0] wc_raw, na, nwa, nwb, nwc;
   logic                 interior;

   always_comb begin
      wc_raw = area_ff - wa_ff - wb_ff;
      if (area_ff < 0) begin
         na = -area_ff; nwa = -wa_ff; nwb = -wb_ff; nwc = -wc_raw;
      end else begin
         na = area_ff;  nwa = wa_ff;  nwb = wb_ff;  nwc = wc_raw;
      end
      interior = (area_ff != '0) && (nwa > 0) && (nwb > 0) && (nwc > 0);
   end

   // weighted depth sum
   logic signed [EW-1:0] msel_w;
   logic signed [ZW-1:0] msel_z;
   logic signed [EW+ZW-1:0] mprod;

   always_comb begin
      case (cmd.mac_sel)
         2'd0:    begin msel_w = wa_ff; msel_z = vz_ff[0]; end
         2'd1:    begin msel_w = wb_ff; msel_z = vz_ff[1]; end
         default: begin msel_w = wc_ff; msel_z = vz_ff[2]; end
      endcase
      mprod = msel_w * msel_z;
   end

   // restoring divider step
   logic [AC-1:0] mag;
   logic [EW+1:0] trial;

   always_comb begin
      mag   = acc_ff[AC-1] ? AC'(-acc_ff) : AC'(acc_ff);
      trial = {1'b0, rem_ff, dvd_ff[15]} - {2'b00, area_ff};
   end

   // depth store
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [ZW-1:0] ram_wdata, ram_rdata;
   logic          pass;

   assign pass = z_ff < $signed(ram_rdata);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = z_ff;
      if (cmd.op == tfdt_pkg::OP_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr;
         ram_wdata = tfdt_pkg::Z_FAR;
      end else if (cmd.op == tfdt_pkg::OP_TEST) begin
         ram_we = pass;
      end
   end

   tfdt_ram #(.WIDTH(ZW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // shade
   logic signed [ZW:0] zd;
   logic [ZW-1:0]      zmag;
   logic [36:0]        gprod;

   always_comb begin
      zd    = (ZW+1)'(z_ff) - (ZW+1)'(tfdt_pkg::GRAY_OFFSET);
      zmag  = zd[ZW] ? ZW'(-zd) : ZW'(zd);
      gprod = 37'(t_ff[17:0]) * 37'(tfdt_pkg::RECIP);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         tfdt_pkg::OP_LOAD: begin
            px_ff <= req_pixel_x;  py_ff <= req_pixel_y;
            vx_ff[0] <= req_v0_x;  vy_ff[0] <= req_v0_y;  vz_ff[0] <= req_v0_z;
            vx_ff[1] <= req_v1_x;  vy_ff[1] <= req_v1_y;  vz_ff[1] <= req_v1_z;
            vx_ff[2] <= req_v2_x;  vy_ff[2] <= req_v2_y;  vz_ff[2] <= req_v2_z;
            off_ff  <= off_in;
            addr_ff <= addr_in;
            cov_ff  <= 1'b0;
            wr_ff   <= 1'b0;
         end
         tfdt_pkg::OP_AREA: area_ff <= edge_v;
         tfdt_pkg::OP_WA:   wa_ff   <= edge_v;
         tfdt_pkg::OP_WB:   wb_ff   <= edge_v;
         tfdt_pkg::OP_CHECK: begin
            area_ff <= na;
            wa_ff   <= nwa;
            wb_ff   <= nwb;
            wc_ff   <= nwc;
            cov_ff  <= interior;
            acc_ff  <= '0;
         end
         tfdt_pkg::OP_MAC: acc_ff <= acc_ff + AC'(mprod);
         tfdt_pkg::OP_DIVINIT: begin
            neg_ff <= acc_ff[AC-1];
            rem_ff <= EW'(mag[AC-1:16]);
            dvd_ff <= mag[15:0];
            quo_ff <= '0;
         end
         tfdt_pkg::OP_DIV: begin
            if (!trial[EW+1]) begin
               rem_ff <= trial[EW-1:0];
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[EW-2:0], dvd_ff[15]};
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            dvd_ff <= {dvd_ff[14:0], 1'b0};
         end
         tfdt_pkg::OP_FINAL: z_ff <= neg_ff ? $signed(-quo_ff) : $signed(quo_ff);
         tfdt_pkg::OP_TEST: begin
            wr_ff <= pass;
            t_ff  <= 24'(zmag) * 24'(tfdt_pkg::GRAY_SCALE);
         end
         tfdt_pkg::OP_GRAY: begin
            if (t_ff >= 24'(tfdt_pkg::GRAY_SAT)) begin
               gray_ff <= 8'd255;
            end else begin
               gray_ff <= gprod[tfdt_pkg::RECIP_SHIFT+7:tfdt_pkg::RECIP_SHIFT];
            end
         end
         default: ;
      endcase
   end

   assign st.offscreen = off_ff;
   assign st.covered   = cov_ff;

   assign rsp_covered       = cov_ff;
   assign rsp_depth_written = wr_ff;
   assign rsp_gray_level    = wr_ff ? gray_ff : 8'd0;
   assign rsp_depth_value   = cov_ff ? z_ff : '0;

endmodule

// ===== rtl/core/tfdt_ctrl.sv =====
`include "assert_macros.svh"

module tfdt_ctrl #(
   parameter int DEPTH = 2 * tfdt_pkg::SCREEN_HALF * tfdt_pkg::ROW_PITCH,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tfdt_pkg::status_type st,
   output tfdt_pkg::cmd_type    cmd,
   output logic [AW-1:0]        clr_addr
);

   typedef enum logic [12:0] {
      ST_CLEAR   = 13'b0000000000001,
      ST_IDLE    = 13'b0000000000010,
      ST_AREA    = 13'b0000000000100,
      ST_WA      = 13'b0000000001000,
      ST_WB      = 13'b0000000010000,
      ST_CHECK   = 13'b0000000100000,
      ST_MAC     = 13'b0000001000000,
      ST_DIVINIT = 13'b0000010000000,
      ST_DIV     = 13'b0000100000000,
      ST_FINAL   = 13'b0001000000000,
      ST_TEST    = 13'b0010000000000,
      ST_GRAY    = 13'b0100000000000,
      ST_RESP    = 13'b1000000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [tfdt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]                clr_ff, clr_in;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      cmd.op      = tfdt_pkg::OP_NONE;
      cmd.mac_sel = cnt_ff[1:0];
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = tfdt_pkg::OP_CLEAR;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = tfdt_pkg::OP_LOAD;
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            // drop off-screen pixels straight to the response
            if (st.offscreen) begin
               state_in = ST_RESP;
            end else begin
               cmd.op   = tfdt_pkg::OP_AREA;
               state_in = ST_WA;
            end
         end
         ST_WA: begin
            cmd.op   = tfdt_pkg::OP_WA;
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.op   = tfdt_pkg::OP_WB;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.op   = tfdt_pkg::OP_CHECK;
            cnt_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (!st.covered) begin
               state_in = ST_RESP;
            end else begin
               cmd.op = tfdt_pkg::OP_MAC;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == tfdt_pkg::CNT_W'(2)) begin
                  state_in = ST_DIVINIT;
               end
            end
         end
         ST_DIVINIT: begin
            cmd.op   = tfdt_pkg::OP_DIVINIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = tfdt_pkg::OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tfdt_pkg::CNT_W'(tfdt_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.op   = tfdt_pkg::OP_FINAL;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cmd.op   = tfdt_pkg::OP_TEST;
            state_in = ST_GRAY;
         end
         ST_GRAY: begin
            cmd.op   = tfdt_pkg::OP_GRAY;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
      end
   end

   assign clr_addr = clr_ff;

   `ASSERT_IMPLY(a_resp_blocks_req, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_valid && req_ready, !req_ready && !rsp_valid)
   `ASSERT_IMPLY(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !req_ready && !rsp_valid)
   `ASSERT_IMPLY(a_store_write_op, clock, reset, cmd.op == tfdt_pkg::OP_CLEAR, state_ff == ST_CLEAR)

endmodule

// ===== rtl/core/triangle_fragment_depth_test_unit.sv =====
// channel | ports                      | direction | handshake
// req     | req_pixel_*, req_v*_*      | in        | req_valid / req_ready
// rsp     | rsp_covered ... depth_value| out       | rsp_valid / rsp_ready
// csr     | csr_index, csr_write_data  | in        | csr_write_enable
//
// A covered pixel presents its result after accept through the area and weight
// edge evaluations and the per-vertex multiply-accumulates on shared units, the 16-bit
// restoring divider, a store test and a shade step.
// Off-screen pixels answer before any edge evaluation, uncovered pixels after the interior test.
// After reset the store clears one entry a cycle over all 2*SCREEN_HALF*ROW_PITCH
// entries with req_ready low; one word in flight, held until rsp_ready.
module triangle_fragment_depth_test_unit #(
   parameter int SCREEN_HALF = tfdt_pkg::SCREEN_HALF,
   parameter int ROW_PITCH   = tfdt_pkg::ROW_PITCH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tfdt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfdt_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tfdt_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic signed [tfdt_pkg::PIX_W-1:0]   req_pixel_y,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v0_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v0_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v0_z,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v1_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v1_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v1_z,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v2_x,
   input  logic signed [tfdt_pkg::VTX_W-1:0]   req_v2_y,
   input  logic signed [tfdt_pkg::Z_W-1:0]     req_v2_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_covered,
   output logic                                rsp_depth_written,
   output logic [7:0]                          rsp_gray_level,
   output logic signed [tfdt_pkg::Z_W-1:0]     rsp_depth_value
);

   localparam int DEPTH = 2 * SCREEN_HALF * ROW_PITCH;
   localparam int AW    = $clog2(DEPTH);

   tfdt_pkg::cmd_type    cmd;
   tfdt_pkg::status_type st;
   logic [AW-1:0]        clr_addr;

   tfdt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   tfdt_dp #(.SCREEN_HALF(SCREEN_HALF), .ROW_PITCH(ROW_PITCH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_v0_x          (req_v0_x),
      .req_v0_y          (req_v0_y),
      .req_v0_z          (req_v0_z),
      .req_v1_x          (req_v1_x),
      .req_v1_y          (req_v1_y),
      .req_v1_z          (req_v1_z),
      .req_v2_x          (req_v2_x),
      .req_v2_y          (req_v2_y),
      .req_v2_z          (req_v2_z),
      .cmd               (cmd),
      .clr_addr          (clr_addr),
      .st                (st),
      .rsp_covered       (rsp_covered),
      .rsp_depth_written (rsp_depth_written),
      .rsp_gray_level    (rsp_gray_level),
      .rsp_depth_value   (rsp_depth_value)
   );

endmodule

// ===== test/testbench.sv =====
module testbench;

   localparam int SCREEN_HALF = tfdt_pkg::SCREEN_HALF;
   localparam int ROW_PITCH   = tfdt_pkg::ROW_PITCH;
   localparam int PIX_W       = tfdt_pkg::PIX_W;
   localparam int VTX_W       = tfdt_pkg::VTX_W;
   localparam int Z_W         = tfdt_pkg::Z_W;
   localparam int CSR_IDX_W   = tfdt_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = tfdt_pkg::CSR_DATA_W;

   localparam int STORE_SIZE = 2 * SCREEN_HALF * ROW_PITCH;
   localparam int STALL_LIMIT = 800000;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 200;

   typedef struct {
      logic signed [PIX_W-1:0] px, py;
      logic signed [VTX_W-1:0] x0, y0;
      logic signed [Z_W-1:0]   z0;
      logic signed [VTX_W-1:0] x1, y1;
      logic signed [Z_W-1:0]   z1;
      logic signed [VTX_W-1:0] x2, y2;
      logic signed [Z_W-1:0]   z2;
   } fragment_type;

   typedef struct {
      logic                  covered;
      logic                  written;
      logic [7:0]            gray;
      logic signed [Z_W-1:0] depth;
   } shade_type;

   typedef struct {
      fragment_type frag;
      bit           typed;
      shade_type    want;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [PIX_W-1:0] req_pixel_x = '0, req_pixel_y = '0;
   logic signed [VTX_W-1:0] req_v0_x = '0, req_v0_y = '0, req_v1_x = '0, req_v1_y = '0;
   logic signed [VTX_W-1:0] req_v2_x = '0, req_v2_y = '0;
   logic signed [Z_W-1:0] req_v0_z = '0, req_v1_z = '0, req_v2_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_covered, rsp_depth_written;
   logic [7:0] rsp_gray_level;
   logic signed [Z_W-1:0] rsp_depth_value;

   triangle_fragment_depth_test_unit dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   logic signed [Z_W-1:0] zbuf [0:STORE_SIZE-1];
   int unsigned hw_cfg = tfdt_pkg::HALF_RESET, hh_cfg = tfdt_pkg::HALF_RESET;
   shade_type pending_shades [$];
   int mismatches = 0;
   bit quiet = 0;
   bit hold_request = 0;
   int stall_cycles = 0;

   function automatic longint edge_val(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by);
      return -(px - ax) * (by - ay) + (py - ay) * (bx - ax);
   endfunction

   // Shade one pixel and update the depth copy.
   function automatic shade_type shade_pixel(fragment_type f);
      shade_type s;
      longint x, y, col, row, area, wa, wb, wc, z, t, g;
      int addr;
      s = '{1'b0, 1'b0, 8'd0, 16'sd0};
      x = f.px;
      y = f.py;
      if (x < -longint'(hw_cfg) || x > longint'(hw_cfg) ||
          y < -longint'(hh_cfg) || y > longint'(hh_cfg))
         return s;
      col = x + SCREEN_HALF;
      row = y + SCREEN_HALF;
      if (col < 0 || col >= ROW_PITCH || row < 0 || row >= 2 * SCREEN_HALF)
         return s;
      area = edge_val(f.x0, f.y0, f.x1, f.y1, f.x2, f.y2);
      if (area == 0) return s;
      wa = edge_val(x, y, f.x1, f.y1, f.x2, f.y2);
      wb = edge_val(x, y, f.x2, f.y2, f.x0, f.y0);
      wc = area - wa - wb;
      if (area < 0) begin
         area = -area; wa = -wa; wb = -wb; wc = -wc;
      end
      if (wa <= 0 || wb <= 0 || wc <= 0) return s;
      z = (wa * f.z0 + wb * f.z1 + wc * f.z2) / area;
      s.covered = 1'b1;
      s.depth = z[Z_W-1:0];
      addr = int'(row * ROW_PITCH + col);
      if (z < longint'(zbuf[addr])) begin
         zbuf[addr] = z[Z_W-1:0];
         s.written = 1'b1;
         t = (z - tfdt_pkg::GRAY_OFFSET) * tfdt_pkg::GRAY_SCALE;
         if (t < 0) t = -t;
         g = t / 1000;
         if (g > 255) g = 255;
         s.gray = g[7:0];
      end
      return s;
   endfunction

   function automatic logic signed [VTX_W-1:0] near_coord(int c);
      int v;
      v = c + int'($urandom_range(0, 128)) - 64;
      return v[VTX_W-1:0];
   endfunction

   logic signed [PIX_W-1:0] pool_x [16], pool_y [16];

   function automatic fragment_type random_fragment();
      fragment_type f;
      int kind;
      int idx;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
         idx = $urandom_range(0, 15);
         f.px = pool_x[idx];
         f.py = pool_y[idx];
      end else begin
         f.px = PIX_W'($urandom);
         f.py = PIX_W'($urandom);
      end
      if ($urandom_range(0, 3) == 0) begin
         f.z0 = Z_W'($urandom); f.z1 = Z_W'($urandom); f.z2 = Z_W'($urandom);
      end else begin
         f.z0 = Z_W'(int'($urandom_range(0, 3000)) - 1000);
         f.z1 = Z_W'(int'($urandom_range(0, 3000)) - 1000);
         f.z2 = Z_W'(int'($urandom_range(0, 3000)) - 1000);
      end
      if (kind < 65) begin
         f.x0 = near_coord(f.px); f.y0 = near_coord(f.py);
         f.x1 = near_coord(f.px); f.y1 = near_coord(f.py);
         f.x2 = near_coord(f.px); f.y2 = near_coord(f.py);
      end else begin
         f.x0 = VTX_W'($urandom); f.y0 = VTX_W'($urandom); f.x1 = VTX_W'($urandom);
         f.y1 = VTX_W'($urandom); f.x2 = VTX_W'($urandom); f.y2 = VTX_W'($urandom);
      end
      if (kind >= 85 && kind < 92) begin
         // collinear: third vertex on the line through the first two
         f.x2 = VTX_W'(f.x0 + (f.x1 - f.x0) * 2);
         f.y2 = VTX_W'(f.y0 + (f.y1 - f.y0) * 2);
      end else if (kind >= 92) begin
         f.x1 = VTX_W'(f.px);
         f.y1 = VTX_W'(f.py);
      end
      return f;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == tfdt_pkg::CSR_HALF_WIDTH) hw_cfg = val;
      else hh_cfg = val;
   endtask

   // Offer one word, wait for acceptance, record what it should produce.
   task automatic send_fragment(fragment_type f, bit typed, shade_type want);
      shade_type s;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel_x = f.px; req_pixel_y = f.py;
      req_v0_x = f.x0; req_v0_y = f.y0; req_v0_z = f.z0;
      req_v1_x = f.x1; req_v1_y = f.y1; req_v1_z = f.z1;
      req_v2_x = f.x2; req_v2_y = f.y2; req_v2_z = f.z2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      s = shade_pixel(f);
      pending_shades.push_back(typed ? want : s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_shades.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int idle_left;
      int hold_left;
      idle_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 13) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      shade_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: cov=%0b wr=%0b gray=%0d z=%0d",
               rsp_covered, rsp_depth_written, rsp_gray_level, rsp_depth_value);
         end else begin
            w = pending_shades.pop_front();
            if (rsp_covered !== w.covered || rsp_depth_written !== w.written ||
                rsp_gray_level !== w.gray || rsp_depth_value !== w.depth) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp cov=%0b wr=%0b gray=%0d z=%0d, got %0b %0b %0d %0d",
                     w.covered, w.written, w.gray, w.depth, rsp_covered,
                     rsp_depth_written, rsp_gray_level, rsp_depth_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("FAIL triangle_fragment_depth_test_unit");
         $finish;
      end
   end

   dir_row_type dir [14];
   shade_type none_s;
   int unsigned hw_set [PHASES] = '{1, 255, 0, 10, 0};
   int unsigned hh_set [PHASES] = '{255, 1, 0, 200, 0};

   initial begin
      for (int i = 0; i < STORE_SIZE; i++) zbuf[i] = tfdt_pkg::Z_FAR;
      for (int i = 0; i < 16; i++) begin
         pool_x[i] = PIX_W'(int'($urandom_range(0, 40)) - 20);
         pool_y[i] = PIX_W'(int'($urandom_range(0, 40)) - 20);
      end
      none_s = '{1'b0, 1'b0, 8'd0, 16'sd0};
      dir[0]  = '{'{-9'sd256, 0, -100, -100, 500, 100, -100, 500, 0, 100, 500}, 1, none_s};
      dir[1]  = '{'{0, 0, -100, -100, 500, 100, 100, 500, 50, 50, 500}, 1, none_s};
      dir[2]  = '{'{0, 0, -100, -100, 500, 100, -100, 500, 0, 100, 500}, 1,
                  '{1'b1, 1'b1, 8'd127, 16'sd500}};
      // equal depth must not pass
      dir[3]  = '{'{0, 0, -100, -100, 500, 100, -100, 500, 0, 100, 500}, 1,
                  '{1'b1, 1'b0, 8'd0, 16'sd500}};
      dir[4]  = '{'{0, 100, -100, -100, 500, 100, -100, 500, 0, 100, 500}, 1, none_s};
      dir[5]  = '{'{0, -100, -100, -100, 500, 100, -100, 500, 0, 100, 500}, 1, none_s};
      dir[6]  = '{'{1, 1, -100, -100, -16'sd32768, 100, -100, -16'sd32768,
                  0, 100, -16'sd32768}, 1, '{1'b1, 1'b1, 8'd255, -16'sd32768}};
      dir[7]  = '{'{2, 2, -100, -100, 32767, 100, -100, 32767, 0, 100, 32767}, 1,
                  '{1'b1, 1'b0, 8'd0, 16'sd32767}};
      dir[8]  = '{'{3, 3, -100, -100, 1000, 100, -100, 1000, 0, 100, 1000}, 1,
                  '{1'b1, 1'b1, 8'd0, 16'sd1000}};
      dir[9]  = '{'{4, 5, 0, 100, -300, 100, -100, 900, -100, -100, 20}, 0, none_s};
      dir[10] = '{'{255, 255, -4096, -4096, -5, 4095, -4096, 7000, 0, 4095, -20000},
                  0, none_s};
      dir[11] = '{'{-255, -255, 4095, 4095, 32767, -4096, 4095, -32768, 0, -4096, 0},
                  0, none_s};
      dir[12] = '{'{255, -9'sd256, -4096, -4096, 1, 4095, -4096, 2, 0, 4095, 3}, 1, none_s};
      dir[13] = '{'{-7, 9, -50, -60, 2000, 70, -40, 600, 10, 80, 100}, 0, none_s};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (dir[i]) send_fragment(dir[i].frag, dir[i].typed, dir[i].want);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_csr(tfdt_pkg::CSR_HALF_WIDTH,
                   CSR_DATA_W'((p == 2) ? $urandom_range(1, 255) : hw_set[p]));
         write_csr(tfdt_pkg::CSR_HALF_HEIGHT,
                   CSR_DATA_W'((p == 2) ? $urandom_range(1, 255) : hh_set[p]));
         if (p == PHASES - 1) begin
            write_csr(tfdt_pkg::CSR_HALF_WIDTH, CSR_DATA_W'(255));
            write_csr(tfdt_pkg::CSR_HALF_HEIGHT, CSR_DATA_W'(255));
            quiet = 1;
         end
         if (p == 1) hold_request = 1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_fragment(random_fragment(), 0, none_s);
         drain();
      end

      if (mismatches == 0 && pending_shades.size() == 0)
         $display("PASS triangle_fragment_depth_test_unit");
      else
         $display("FAIL triangle_fragment_depth_test_unit");
      $finish;
   end
endmodule
